[rtl/lzwd_pkg.sv]
// Package for the LZW variable-width decoder.
// Holds the channel payload types, the front-to-back command and shared constants.
// No dependencies.
package lzwd_pkg;

  localparam int DICT_AW       = 12;
  localparam int LITERAL_COUNT = 256;
  localparam int MIN_WIDTH     = 9;
  localparam int MAX_WIDTH     = 12;
  localparam int CHUNK_BYTES   = 64;
  localparam int QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [63:0] bytes_0_to_7;
    logic [63:0] bytes_8_to_15;
    logic [63:0] bytes_16_to_23;
    logic [63:0] bytes_24_to_31;
    logic [63:0] bytes_32_to_39;
    logic [63:0] bytes_40_to_47;
    logic [63:0] bytes_48_to_55;
    logic [63:0] bytes_56_to_63;
    logic [6:0]  byte_count;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic               is_lit;
    logic               add_en;
    logic               known;
    logic [DICT_AW-1:0] code;
    logic [DICT_AW-1:0] prev;
    logic [DICT_AW-1:0] new_idx;
    logic [DICT_AW-1:0] emit;
  } cmd_t;

endpackage

[rtl/lzwd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lzwd_front.sv]
// Front end: takes compressed bytes, runs the bit buffer, code width and entry count,
// and emits one command per literal or completed code. Depends on lzwd_pkg.
module lzwd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lzwd_pkg::in_item_t in_data,
  output logic              push,
  output lzwd_pkg::cmd_t    push_cmd,
  input  logic              q_full
);
  import lzwd_pkg::*;

  logic [19:0]        store_r, store_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [3:0]         width_r, width_nxt;
  logic [12:0]        count_r, count_nxt;
  logic [DICT_AW-1:0] prev_r, prev_nxt;

  logic               accept, lit, have, known, add_en;
  logic [19:0]        store_sh;
  logic [4:0]         cnt_sh, rest;
  logic [DICT_AW-1:0] code, emit;
  logic [12:0]        count_add;
  logic [13:0]        limit;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign lit      = in_data.start_of_stream || (width_r > 4'(MAX_WIDTH));
  assign store_sh = {store_r[11:0], in_data.data_byte};
  assign cnt_sh   = cnt_r + 5'd8;
  assign have     = cnt_sh >= {1'b0, width_r};
  assign rest     = cnt_sh - {1'b0, width_r};
  assign code     = DICT_AW'(store_sh >> rest);
  assign known    = {1'b0, code} < count_r;
  assign add_en   = count_r < 13'(1 << DICT_AW);
  assign count_add = add_en ? count_r + 13'd1 : count_r;
  assign limit    = 14'd1 << width_r;
  assign emit     = known ? code : DICT_AW'(count_add - 13'd1);

  always_comb begin
    store_nxt = store_r;
    cnt_nxt   = cnt_r;
    width_nxt = width_r;
    count_nxt = count_r;
    prev_nxt  = prev_r;
    push      = 1'b0;
    push_cmd  = '0;
    if (accept) begin
      if (lit) begin
        store_nxt = '0;
        cnt_nxt   = '0;
        width_nxt = 4'(MIN_WIDTH);
        count_nxt = 13'(LITERAL_COUNT);
        prev_nxt  = {4'b0, in_data.data_byte};
        push      = 1'b1;
        push_cmd.is_lit = 1'b1;
        push_cmd.code   = {4'b0, in_data.data_byte};
      end else if (have) begin
        store_nxt = store_sh & ((20'd1 << rest) - 20'd1);
        cnt_nxt   = rest;
        count_nxt = count_add;
        if (width_r < 4'd15 && {1'b0, count_add} >= limit) begin
          width_nxt = width_r + 4'd1;
        end
        prev_nxt  = emit;
        push      = 1'b1;
        push_cmd.add_en  = add_en;
        push_cmd.known   = known;
        push_cmd.code    = code;
        push_cmd.prev    = prev_r;
        push_cmd.new_idx = count_r[DICT_AW-1:0];
        push_cmd.emit    = emit;
      end else begin
        store_nxt = store_sh;
        cnt_nxt   = cnt_sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      cnt_r   <= '0;
      width_r <= 4'(MIN_WIDTH);
      count_r <= 13'(LITERAL_COUNT);
      prev_r  <= '0;
    end else begin
      store_r <= store_nxt;
      cnt_r   <= cnt_nxt;
      width_r <= width_nxt;
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r < 5'd13 && cnt_r < {1'b0, width_r})
    else $error("bit buffer holds a whole code");
  assert property (@(posedge clk) disable iff (!rst_n)
                   width_r >= 4'(MIN_WIDTH) && width_r <= 4'(MAX_WIDTH + 1))
    else $error("code width out of range");
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= 13'(1 << DICT_AW))
    else $error("entry count out of range");

endmodule

[rtl/lzwd_queue.sv]
// Short command queue between front and back ends, in flip-flops.
// Depends on lzwd_pkg.
module lzwd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lzwd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output lzwd_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import lzwd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   fill_r;

  assign head  = slot_r[rp_r];
  assign full  = fill_r == (PW+1)'(QUEUE_DEPTH);
  assign empty = fill_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(QUEUE_DEPTH-1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(QUEUE_DEPTH-1)) ? '0 : rp_r + PW'(1);
      end
      fill_r <= fill_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= (PW+1)'(QUEUE_DEPTH))
    else $error("queue fill out of range");

endmodule

[rtl/lzwd_back.sv]
// Back end: updates the dictionary, walks the prefix chain into the reverse buffer
// and packs the string into 64-byte results. Depends on lzwd_pkg and lzwd_ram.
module lzwd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  lzwd_pkg::cmd_t      q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output lzwd_pkg::out_item_t out_data
);
  import lzwd_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD0   = 9'b000000010,
    S_RD1   = 9'b000000100,
    S_RD2   = 9'b000001000,
    S_WALK0 = 9'b000010000,
    S_WALK  = 9'b000100000,
    S_CHUNK = 9'b001000000,
    S_FILL  = 9'b010000000,
    S_SEND  = 9'b100000000
  } state_t;

  localparam logic [DICT_AW-1:0] MAX_LEN = '1;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [7:0]         hp_r, hp_nxt;
  logic [DICT_AW-1:0] lp_r, lp_nxt;
  logic [DICT_AW-1:0] c_r, c_nxt;
  logic [DICT_AW-1:0] i_r, i_nxt;
  logic [DICT_AW-1:0] tot_r, tot_nxt;
  logic [DICT_AW-1:0] pos_r, pos_nxt;
  logic [DICT_AW-1:0] rem_r, rem_nxt;
  logic [6:0]         n_r, n_nxt;
  logic [6:0]         iss_r, iss_nxt;
  logic [6:0]         got_r, got_nxt;
  logic               pend_r, pend_nxt;
  logic               ov_r, ov_nxt;
  logic [511:0]       data_r, data_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic               last_r, last_nxt;

  logic               d_we, rev_we;
  logic [DICT_AW-1:0] d_waddr, h_raddr, l_raddr, pt_raddr, rev_waddr, rev_raddr;
  logic [DICT_AW-1:0] p_wdata, l_wdata, p_q, l_q;
  logic [7:0]         t_wdata, h_wdata, t_q, h_q, rev_wdata, rev_q;
  logic [7:0]         hc;
  logic [DICT_AW-1:0] lc, newlen;

  lzwd_ram #(.WIDTH(DICT_AW), .DEPTH(1 << DICT_AW)) u_prefix (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(p_wdata), .raddr(pt_raddr), .rdata(p_q));
  lzwd_ram #(.WIDTH(8), .DEPTH(1 << DICT_AW)) u_tail (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(t_wdata), .raddr(pt_raddr), .rdata(t_q));
  lzwd_ram #(.WIDTH(8), .DEPTH(1 << DICT_AW)) u_head (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_q));
  lzwd_ram #(.WIDTH(DICT_AW), .DEPTH(1 << DICT_AW)) u_len (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_q));
  lzwd_ram #(.WIDTH(8), .DEPTH(1 << DICT_AW)) u_rev (
    .clk, .we(rev_we), .waddr(rev_waddr), .wdata(rev_wdata), .raddr(rev_raddr),
    .rdata(rev_q));

  function automatic logic is_literal(input logic [DICT_AW-1:0] c);
    return c < DICT_AW'(LITERAL_COUNT);
  endfunction

  assign hc     = is_literal(cmd_r.code) ? cmd_r.code[7:0] : h_q;
  assign lc     = is_literal(cmd_r.code) ? DICT_AW'(1) : l_q;
  assign newlen = (lp_r == MAX_LEN) ? MAX_LEN : lp_r + DICT_AW'(1);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    hp_nxt    = hp_r;
    lp_nxt    = lp_r;
    c_nxt     = c_r;
    i_nxt     = i_r;
    tot_nxt   = tot_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    n_nxt     = n_r;
    iss_nxt   = iss_r;
    got_nxt   = got_r;
    pend_nxt  = pend_r;
    ov_nxt    = ov_r;
    data_nxt  = data_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    d_we      = 1'b0;
    d_waddr   = cmd_r.new_idx;
    p_wdata   = cmd_r.prev;
    t_wdata   = cmd_r.known ? hc : hp_r;
    h_wdata   = hp_r;
    l_wdata   = newlen;
    h_raddr   = cmd_r.prev;
    l_raddr   = cmd_r.prev;
    pt_raddr  = c_r;
    rev_we    = 1'b0;
    rev_waddr = i_r - DICT_AW'(1);
    rev_wdata = t_q;
    rev_raddr = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cmd_nxt = q_head;
          if (q_head.is_lit) begin
            data_nxt  = {504'b0, q_head.code[7:0]};
            cnt_nxt   = 7'd1;
            last_nxt  = 1'b1;
            ov_nxt    = 1'b1;
            state_nxt = S_SEND;
          end else begin
            state_nxt = S_RD0;
          end
        end
      end
      S_RD0: state_nxt = S_RD1;
      S_RD1: begin
        hp_nxt    = is_literal(cmd_r.prev) ? cmd_r.prev[7:0] : h_q;
        lp_nxt    = is_literal(cmd_r.prev) ? DICT_AW'(1) : l_q;
        h_raddr   = cmd_r.code;
        l_raddr   = cmd_r.code;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        d_we      = cmd_r.add_en;
        c_nxt     = cmd_r.emit;
        i_nxt     = cmd_r.known ? lc : newlen;
        tot_nxt   = i_nxt;
        state_nxt = S_WALK0;
      end
      S_WALK0: state_nxt = S_WALK;
      S_WALK: begin
        rev_we = 1'b1;
        if (is_literal(c_r) || i_r == DICT_AW'(1)) begin
          if (is_literal(c_r)) begin
            rev_wdata = c_r[7:0];
          end
          pos_nxt   = '0;
          rem_nxt   = tot_r;
          state_nxt = S_CHUNK;
        end else begin
          i_nxt    = i_r - DICT_AW'(1);
          c_nxt    = p_q;
          pt_raddr = p_q;
        end
      end
      S_CHUNK: begin
        n_nxt     = (rem_r > DICT_AW'(CHUNK_BYTES)) ? 7'(CHUNK_BYTES) : 7'(rem_r);
        data_nxt  = '0;
        iss_nxt   = '0;
        got_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        pend_nxt = iss_r < n_r;
        if (iss_r < n_r) begin
          pos_nxt = pos_r + DICT_AW'(1);
          iss_nxt = iss_r + 7'd1;
        end
        if (pend_r) begin
          data_nxt[{got_r[5:0], 3'b000} +: 8] = rev_q;
          got_nxt = got_r + 7'd1;
          if (got_r + 7'd1 == n_r) begin
            cnt_nxt   = n_r;
            last_nxt  = rem_r == {5'b0, n_r};
            rem_nxt   = rem_r - {5'b0, n_r};
            ov_nxt    = 1'b1;
            state_nxt = S_SEND;
          end
        end
      end
      S_SEND: begin
        if (!out_stall) begin
          ov_nxt    = 1'b0;
          state_nxt = last_r ? S_IDLE : S_CHUNK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    hp_r   <= hp_nxt;
    lp_r   <= lp_nxt;
    c_r    <= c_nxt;
    i_r    <= i_nxt;
    tot_r  <= tot_nxt;
    pos_r  <= pos_nxt;
    rem_r  <= rem_nxt;
    n_r    <= n_nxt;
    iss_r  <= iss_nxt;
    got_r  <= got_nxt;
    data_r <= data_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = ov_r;
  assign out_data.bytes_0_to_7   = data_r[63:0];
  assign out_data.bytes_8_to_15  = data_r[127:64];
  assign out_data.bytes_16_to_23 = data_r[191:128];
  assign out_data.bytes_24_to_31 = data_r[255:192];
  assign out_data.bytes_32_to_39 = data_r[319:256];
  assign out_data.bytes_40_to_47 = data_r[383:320];
  assign out_data.bytes_48_to_55 = data_r[447:384];
  assign out_data.bytes_56_to_63 = data_r[511:448];
  assign out_data.byte_count     = cnt_r;
  assign out_data.last_of_run    = last_r;

  assert property (@(posedge clk) disable iff (!rst_n) ov_r |-> state_r == S_SEND)
    else $error("result shown outside send state");
  assert property (@(posedge clk) disable iff (!rst_n)
                   ov_r |-> (cnt_r != 7'd0 && cnt_r <= 7'(CHUNK_BYTES)))
    else $error("byte count out of range");
  assert property (@(posedge clk) disable iff (!rst_n) state_r == S_WALK |-> i_r != '0)
    else $error("chain walk ran past the string start");

endmodule

[rtl/lzw_variable_width_decoder.sv]
// Top level of the LZW variable-width decoder (9 to 12 bit codes).
// Depends on lzwd_pkg, lzwd_front, lzwd_queue, lzwd_back.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | lzwd_pkg::in_item_t
//   out     | output    | out_valid/out_stall| lzwd_pkg::out_item_t
//
// A literal byte holds the back end for a pop, then its result shows the next cycle.
// For a code with a string of L bytes, the back end reads and updates the dictionary,
// then walks the chain over the prefix RAM, one entry a cycle, then reads out the reverse
// buffer RAM. Worst case L = 3841. Bytes that complete no code only fill the bit buffer.
// Reset is synchronous; dictionary RAMs need no clearing. Output stall holds the back end
// only; the front keeps accepting until the queue fills.
module lzw_variable_width_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lzwd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lzwd_pkg::out_item_t out_data
);
  import lzwd_pkg::*;

  logic push, pop, q_full, q_empty;
  cmd_t push_cmd, q_head;

  lzwd_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .push, .push_cmd, .q_full);

  lzwd_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .pop, .head(q_head), .full(q_full), .empty(q_empty));

  lzwd_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .pop, .out_valid, .out_stall, .out_data);

endmodule
